// ===== design/fbpa_pkg.sv =====
// fbpa_pkg: shared constants, types and helpers for the block pool allocator.
// No dependencies; used by every module of the block but fbpa_ram.
package fbpa_pkg;

    localparam int NUM_BLOCKS  = 256;
    localparam int INDEX_SPAN  = 256;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int BLOCK_LIMIT = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_FREE    = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

    typedef struct packed {
        logic issue;
        logic exec;
        logic fmt;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic clr_last;
    } stat_t;

    // clamp the programmed block count to 1 .. BLOCK_LIMIT
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = 9'd1;
        end
        else if (n > CNT_W'(BLOCK_LIMIT))
        begin
            r = CNT_W'(BLOCK_LIMIT);
        end
        return r;
    endfunction

endpackage

// ===== design/fixed_block_pool_allocator.sv =====
// fixed_block_pool_allocator: top level of the fixed-size block pool allocator.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp (and fbpa_ram through fbpa_dp).
//
// Usage:
//   s_axis carries requests: tuser is the operation (allocate or free), tdata
//   the block to free. m_axis returns one item per request: tuser the status
//   (ok, pool empty, invalid free), tdata the granted block and the count of
//   blocks in use after the request. cfg writes the block count and formats
//   the pool; write it only while no request is outstanding.
//   For each item the accept edge starts a registered read of the link and
//   mark memories, and the exec edge applies the update and loads the result
//   register; exec waits while a result is held in that register and not taken.
//   A new request is accepted only after the current one has loaded the result register.
//   m_axis_tvalid rises at the edge that loads the result register.
//   Reset and every cfg write format the pool, then a pass over all 256 entries writes
//   the ascending links and free marks; s_axis_tready and cfg_ready are low
//   during the pass. s_axis_tready is also low while cfg_valid is high.
//   One result can wait in the output register while the next request is
//   accepted; that request then holds until the result is taken.
module fixed_block_pool_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] block_index
    input  logic [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] granted_index, [16:8] used_count
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data        // [8:0] block_count
);

    fbpa_pkg::cmd_t  cmd;
    fbpa_pkg::stat_t stat;
    logic [fbpa_pkg::IDX_W-1:0] granted;
    logic [fbpa_pkg::CNT_W-1:0] used;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbpa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_axis_tuser[0]),
        .in_idx      (s_axis_tdata),
        .cfg_data    (cfg_data),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_status  (m_axis_tuser),
        .out_granted (granted),
        .out_used    (used)
    );

    assign m_axis_tdata = {7'd0, used, granted};

endmodule

// ===== design/fbpa_ram.sv =====
// fbpa_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/fbpa_ctrl.sv =====
// fbpa_ctrl: sequencing state machine for the block pool allocator.
// Depends on fbpa_pkg.
module fbpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          out_ready,
    input  fbpa_pkg::stat_t stat,
    output fbpa_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       slot_free;

    assign slot_free = !stat.out_busy || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.fmt    = 1'b1;
                    state_next = S_CLEAR;
                end
                else if (in_valid)
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/fbpa_dp.sv =====
// fbpa_dp: free list datapath - link and mark memories, list pointers, result register.
// Depends on fbpa_pkg and fbpa_ram.
module fbpa_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fbpa_pkg::cmd_t               cmd,
    output fbpa_pkg::stat_t              stat,
    input  logic                         in_op,
    input  logic [fbpa_pkg::IDX_W-1:0]   in_idx,
    input  logic [fbpa_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [1:0]                   out_status,
    output logic [fbpa_pkg::IDX_W-1:0]   out_granted,
    output logic [fbpa_pkg::CNT_W-1:0]   out_used
);

    localparam int IW = fbpa_pkg::IDX_W;
    localparam int CW = fbpa_pkg::CNT_W;
    localparam int NE = fbpa_pkg::INDEX_SPAN;

    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          nonempty_reg, nonempty_next;
    logic [CW-1:0] used_reg, used_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic          op_reg;
    logic [IW-1:0] idx_reg;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg;
    logic [IW-1:0] out_granted_reg;
    logic [CW-1:0] out_used_reg;

    logic          link_we;
    logic [IW-1:0] link_waddr, link_wdata, link_rdata;
    logic          mark_we, mark_wdata, mark_rdata;
    logic [IW-1:0] mark_waddr;

    logic [CW-1:0] eff;
    logic [CW-1:0] eff_new;
    logic [1:0]    res_status;
    logic [IW-1:0] res_granted;

    fbpa_ram #(.WIDTH(IW), .DEPTH(NE)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd.issue),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    fbpa_ram #(.WIDTH(1), .DEPTH(NE)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.issue),
        .raddr (in_idx),
        .rdata (mark_rdata)
    );

    assign eff     = fbpa_pkg::eff_count(count_reg);
    assign eff_new = fbpa_pkg::eff_count(cfg_data);

    assign stat.out_busy = out_valid_reg;
    assign stat.clr_last = (clr_idx_reg == IW'(NE - 1));
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_granted   = out_granted_reg;
    assign out_used      = out_used_reg;

    always_comb
    begin
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        used_next     = used_reg;
        clr_idx_next  = clr_idx_reg;
        link_we       = 1'b0;
        link_waddr    = tail_reg;
        link_wdata    = idx_reg;
        mark_we       = 1'b0;
        mark_waddr    = idx_reg;
        mark_wdata    = 1'b0;
        res_status    = fbpa_pkg::ST_OK;
        res_granted   = '0;

        // clearing pass: one entry a cycle gets its ascending link and a free mark
        if (cmd.clr)
        begin
            link_we      = 1'b1;
            link_waddr   = clr_idx_reg;
            link_wdata   = clr_idx_reg + 8'd1;
            mark_we      = 1'b1;
            mark_waddr   = clr_idx_reg;
            mark_wdata   = 1'b0;
            clr_idx_next = clr_idx_reg + 8'd1;
        end

        if (cmd.exec)
        begin
            if (op_reg == fbpa_pkg::OP_ALLOC)
            begin
                if (!nonempty_reg)
                begin
                    res_status = fbpa_pkg::ST_EMPTY;
                end
                else
                begin
                    res_granted = head_reg;
                    mark_we     = 1'b1;
                    mark_waddr  = head_reg;
                    mark_wdata  = 1'b1;
                    if (head_reg == tail_reg)
                    begin
                        nonempty_next = 1'b0;
                    end
                    else
                    begin
                        head_next = link_rdata;
                    end
                    used_next = used_reg + 9'd1;
                end
            end
            else
            begin
                if (({1'b0, idx_reg} >= eff) || !mark_rdata)
                begin
                    res_status = fbpa_pkg::ST_INVALID;
                end
                else
                begin
                    mark_we = 1'b1;
                    if (!nonempty_reg)
                    begin
                        head_next     = idx_reg;
                        nonempty_next = 1'b1;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                    tail_next = idx_reg;
                    used_next = used_reg - 9'd1;
                end
            end
        end

        if (cmd.fmt)
        begin
            count_next    = cfg_data;
            head_next     = '0;
            tail_next     = IW'(eff_new - 9'd1);
            nonempty_next = 1'b1;
            used_next     = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= fbpa_pkg::COUNT_RESET;
            head_reg      <= '0;
            tail_reg      <= IW'(fbpa_pkg::eff_count(fbpa_pkg::COUNT_RESET) - 9'd1);
            nonempty_reg  <= 1'b1;
            used_reg      <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nonempty_reg  <= nonempty_next;
            used_reg      <= used_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            op_reg  <= in_op;
            idx_reg <= in_idx;
        end
        if (cmd.exec)
        begin
            out_status_reg  <= res_status;
            out_granted_reg <= res_granted;
            out_used_reg    <= used_next;
        end
    end

endmodule

// ===== design/fbpa_checker.sv =====
// fbpa_port_checks: port-level assertions for the block pool allocator, bound to the top.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module fbpa_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // only one request in flight: busy the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // granted index is zero unless the status is ok
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != fbpa_pkg::ST_OK) |-> m_axis_tdata[7:0] == 8'd0)
        else $error("granted index set on failed request");

    // blocks in use never exceed 256, the largest pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:8] <= 9'd256)
        else $error("used count beyond pool size");

endmodule

bind fixed_block_pool_allocator fbpa_port_checks u_fbpa_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/fbpa_checker.sv =====
// fbpa_checker: watches the request, result and config channels of the block pool
// allocator, predicts each result and compares it field by field.
// Depends on fbpa_pkg for widths, operation and status codes.
`timescale 1ns / 100ps
module fbpa_checker
    import fbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] block_index
    input  logic [0:0]  s_axis_tuser,   // [0] op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] granted_index, [16:8] used_count
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,       // [8:0] block_count
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] used;
    } pool_reply_t;

    pool_reply_t      replies_due [$];
    logic [IDX_W-1:0] link_mem [INDEX_SPAN];
    logic             in_use [INDEX_SPAN];
    logic [IDX_W-1:0] head_blk;
    logic [IDX_W-1:0] tail_blk;
    logic             list_live;
    logic [CNT_W-1:0] used_blocks;
    logic [CNT_W-1:0] count_reg;

    function automatic int pool_size(input logic [CNT_W-1:0] n);
        int v;
        v = int'(n);
        if (v < 1)
        begin
            v = 1;
        end
        if (v > BLOCK_LIMIT)
        begin
            v = BLOCK_LIMIT;
        end
        return v;
    endfunction

    function automatic void format_pool();
        for (int i = 0; i < INDEX_SPAN; i++)
        begin
            link_mem[i] = IDX_W'(i + 1);
            in_use[i]   = 1'b0;
        end
        head_blk    = '0;
        tail_blk    = IDX_W'(pool_size(count_reg) - 1);
        list_live   = 1'b1;
        used_blocks = '0;
    endfunction

    function automatic pool_reply_t serve_request(input logic op, input logic [IDX_W-1:0] idx);
        pool_reply_t r;
        r        = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC)
        begin
            if (!list_live)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.granted        = head_blk;
                in_use[head_blk] = 1'b1;
                if (head_blk == tail_blk)
                begin
                    list_live = 1'b0;
                end
                else
                begin
                    head_blk = link_mem[head_blk];
                end
                used_blocks = used_blocks + 1'b1;
            end
        end
        else if (int'(idx) >= pool_size(count_reg) || !in_use[idx])
        begin
            r.status = ST_INVALID;
        end
        else
        begin
            in_use[idx] = 1'b0;
            if (!list_live)
            begin
                head_blk  = idx;
                tail_blk  = idx;
                list_live = 1'b1;
            end
            else
            begin
                link_mem[tail_blk] = idx;
                tail_blk           = idx;
            end
            used_blocks = used_blocks - 1'b1;
        end
        r.used = used_blocks;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pool_reply_t want;
        if (!rst_n)
        begin
            count_reg  = COUNT_RESET;
            format_pool();
            replies_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("unexpected result: tuser %0d tdata 0x%06h", m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:0] !== want.granted)
                    begin
                        $error("granted_index: expected %0d, got %0d",
                               want.granted, m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[16:8] !== want.used)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.used, m_axis_tdata[16:8]);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                count_reg = cfg_data;
                format_pool();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                replies_due.push_back(serve_request(s_axis_tuser[0], s_axis_tdata));
            end
        end
        outstanding = replies_due.size();
    end

endmodule

// ===== tb/tb_fixed_block_pool_allocator.sv =====
// tb_fixed_block_pool_allocator: stimulus and verdict for the block pool allocator.
// Depends on fbpa_pkg, the design and fbpa_checker, which predicts and compares every result.
`timescale 1ns / 100ps
module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASES        = 12;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 4;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] block_index
    logic [0:0]  s_axis_tuser;      // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;      // [7:0] granted_index, [16:8] used_count
    logic [1:0]  m_axis_tuser;      // [1:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;          // [8:0] block_count

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int phase_no = -1;
    int quiet;

    logic [CNT_W-1:0] pool_cfg;
    logic [IDX_W-1:0] held_blocks [$];
    logic             op_log [$];

    fixed_block_pool_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    fbpa_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // receiver: random stalls, plus one long hold-off in each of two phases
    initial
    begin
        int hold_left;
        int last_hold;
        hold_left     = 0;
        last_hold     = -1;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase_no != last_hold && (phase_no == 5 || phase_no == 10))
            begin
                last_hold = phase_no;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // blocks granted so far, for well-formed frees
    always @(posedge clk)
    begin
        logic op;
        if (m_axis_tvalid && m_axis_tready && op_log.size() != 0)
        begin
            op = op_log.pop_front();
            if (op == OP_ALLOC && m_axis_tuser == ST_OK)
            begin
                held_blocks.push_back(m_axis_tdata[7:0]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic push_request(input logic op, input logic [IDX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IDX_W'($urandom);
            s_axis_tuser  <= 1'($urandom);
            do
            begin
                @(negedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        op_log.push_back(op);
        @(negedge clk);
    endtask

    task automatic write_block_count(input logic [CNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        pool_cfg = value;
        held_blocks.delete();
    endtask

    task automatic random_request(input int alloc_pct);
        int lim;
        int pick;
        int n;
        logic [IDX_W-1:0] idx;
        lim = (pool_cfg == 0) ? 1 : ((pool_cfg > BLOCK_LIMIT) ? BLOCK_LIMIT : int'(pool_cfg));
        if ($urandom_range(99) < alloc_pct)
        begin
            push_request(OP_ALLOC, IDX_W'($urandom));
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 60 && held_blocks.size() != 0)
            begin
                n   = $urandom_range(held_blocks.size() - 1);
                idx = held_blocks[n];
                held_blocks.delete(n);
            end
            else if (pick < 85)
            begin
                idx = IDX_W'($urandom_range(lim - 1));
            end
            else
            begin
                idx = IDX_W'($urandom);
            end
            push_request(OP_FREE, idx);
        end
    endtask

    initial
    begin
        int seg_left;
        int alloc_pct;
        logic [CNT_W-1:0] count_val;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        pool_cfg      = COUNT_RESET;
        send_idle_pct = 12;
        recv_idle_pct = 73;
        seg_left      = 0;
        alloc_pct     = 50;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset pool of 256: frees of unused blocks, double free, reuse order
        push_request(OP_FREE, 8'd0);
        push_request(OP_FREE, 8'd255);
        push_request(OP_ALLOC, 8'd255);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_FREE, 8'd1);
        push_request(OP_FREE, 8'd1);
        push_request(OP_FREE, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        // single block: last block taken, empty pool, out of range, free into empty list
        write_block_count(9'd1);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_FREE, 8'd200);
        push_request(OP_FREE, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        // zero and oversized counts clamp
        write_block_count(9'd0);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_FREE, 8'd1);
        write_block_count(9'd511);
        push_request(OP_FREE, 8'd255);
        write_block_count(9'd2);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_ALLOC, 8'd0);
        push_request(OP_FREE, 8'd1);
        push_request(OP_FREE, 8'd0);
        push_request(OP_ALLOC, 8'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count_val = 9'd256;
                1:       count_val = 9'd8;
                2:       count_val = 9'd3;
                3:       count_val = 9'd1;
                4:       count_val = 9'd0;
                5:       count_val = 9'd64;
                6:       count_val = 9'd300;
                7:       count_val = 9'd511;
                8:       count_val = 9'd2;
                9:       count_val = 9'd200;
                10:      count_val = 9'd17;
                default: count_val = 9'd256;
            endcase
            if (p < 4)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 73;
            end
            else if (p < 8)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_block_count(count_val);
            phase_no = p;
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(30, 4);
                    case ($urandom_range(2))
                        0:       alloc_pct = 85;
                        1:       alloc_pct = 20;
                        default: alloc_pct = 50;
                    endcase
                end
                seg_left--;
                random_request(alloc_pct);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fbpa_pkg.sv
design/fbpa_ram.sv
design/fbpa_ctrl.sv
design/fbpa_dp.sv
design/fixed_block_pool_allocator.sv
design/fbpa_checker.sv
tb/fbpa_checker.sv
tb/tb_fixed_block_pool_allocator.sv
